[rtl/fpa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants for the frame pacing accumulator
// Beat payload structs, register indexes, controller commands and states.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int unsigned TIME_W   = 64;
  localparam int unsigned NS_W     = 30;
  localparam int unsigned SUM_W    = NS_W + 1;
  localparam int unsigned MOD_STEPS = SUM_W;
  localparam int unsigned MOD_CNT_W = $clog2(MOD_STEPS);

  localparam logic [NS_W-1:0] RESET_PERIOD_NS  = NS_W'(16666667);
  localparam logic [NS_W-1:0] RESET_MAX_GAP_NS = NS_W'(250000000);

  // Configuration register indexes.
  localparam logic REG_FRAME_PERIOD = 1'b0;
  localparam logic REG_MAX_GAP      = 1'b1;

  // Item operations.
  localparam logic OP_INIT = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NOT_INIT = 1'b1;

  typedef struct packed {
    logic              op;
    logic [TIME_W-1:0] now_ns;
  } in_item_t;

  typedef struct packed {
    logic            render;
    logic [NS_W-1:0] frame_delta_ns;
    logic            status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_CLAMP,
    S_SUM,
    S_COMMIT,
    S_MOD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic diff;
    logic clamp;
    logic sum;
    logic commit;
    logic mod_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_mod;
  } dp_status_t;

endpackage : fpa_pkg
`default_nettype wire

[rtl/fpa_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_ctrl: sequencing state machine
// Steps one item through the datapath, runs the remainder loop and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module fpa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire fpa_pkg::dp_status_t status,
  output fpa_pkg::ctrl_cmd_t      cmd
);
  import fpa_pkg::*;

  state_t               state;
  state_t               state_next;
  logic [MOD_CNT_W-1:0] mod_cnt;
  logic                 mod_last;
  logic                 slot_free;

  assign mod_last  = (mod_cnt == MOD_CNT_W'(MOD_STEPS - 1));
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_DIFF;
      S_DIFF:   state_next = S_CLAMP;
      S_CLAMP:  state_next = S_SUM;
      S_SUM:    state_next = S_COMMIT;
      S_COMMIT: state_next = status.need_mod ? S_MOD : S_DONE;
      S_MOD:    if (mod_last) state_next = S_DONE;
      S_DONE:   if (slot_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_DIFF:   cmd.diff     = 1'b1;
      S_CLAMP:  cmd.clamp    = 1'b1;
      S_SUM:    cmd.sum      = 1'b1;
      S_COMMIT: cmd.commit   = 1'b1;
      S_MOD:    cmd.mod_step = 1'b1;
      S_DONE:   cmd.out_load = slot_free;
      default:  cmd          = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mod_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_COMMIT) begin
        mod_cnt <= '0;
      end else if (state == S_MOD) begin
        mod_cnt <= mod_cnt + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule : fpa_ctrl
`default_nettype wire

[rtl/fpa_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_datapath: timing state, clamps, accumulator and remainder unit
// Holds the configuration and pacing state and the output register.
// ----------------------------------------------------------------------------
module fpa_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire fpa_pkg::ctrl_cmd_t           cmd,
  output fpa_pkg::dp_status_t               status,
  input  wire fpa_pkg::in_item_t            in_item,
  output fpa_pkg::out_item_t                out_item,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [fpa_pkg::NS_W-1:0]     cfg_data
);
  import fpa_pkg::*;

  // Configuration and pacing state.
  logic [NS_W-1:0]   frame_period;
  logic [NS_W-1:0]   max_gap;
  logic [TIME_W-1:0] last_poll;
  logic [TIME_W-1:0] last_frame;
  logic [NS_W-1:0]   bank;
  logic [NS_W-1:0]   delta_held;
  logic              started;

  // Per-item working registers.
  logic              op_q;
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] poll_diff;
  logic              poll_fwd;
  logic [TIME_W-1:0] frame_diff;
  logic              frame_fwd;
  logic [NS_W-1:0]   elapsed;
  logic [NS_W-1:0]   frame_gap;
  logic [SUM_W-1:0]  sum;
  logic              render_q;
  logic              status_q;

  // Remainder unit.
  logic [SUM_W-1:0]  quo;
  logic [NS_W-1:0]   rem;
  logic [SUM_W-1:0]  rem_shift;
  logic [NS_W-1:0]   rem_next;

  logic [NS_W-1:0]   period_eff;
  logic              poll_live;
  logic              reach;

  assign period_eff = (frame_period == '0) ? NS_W'(1) : frame_period;
  assign poll_live  = (op_q == OP_POLL) && started;
  assign reach      = (sum >= {1'b0, period_eff});
  assign status.need_mod = poll_live && reach;

  assign rem_shift = {rem, quo[SUM_W-1]};
  assign rem_next  = (rem_shift >= {1'b0, period_eff}) ?
                     NS_W'(rem_shift - {1'b0, period_eff}) : NS_W'(rem_shift);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= in_item.op;
      now_q <= in_item.now_ns;
    end
    if (cmd.diff) begin
      poll_diff  <= now_q - last_poll;
      poll_fwd   <= now_q > last_poll;
      frame_diff <= now_q - last_frame;
      frame_fwd  <= now_q > last_frame;
    end
    if (cmd.clamp) begin
      if (!poll_fwd) begin
        elapsed <= '0;
      end else if (poll_diff > {{(TIME_W-NS_W){1'b0}}, max_gap}) begin
        elapsed <= max_gap;
      end else begin
        elapsed <= poll_diff[NS_W-1:0];
      end
      if (!frame_fwd) begin
        frame_gap <= '0;
      end else if (frame_diff > {{(TIME_W-NS_W){1'b0}}, max_gap}) begin
        frame_gap <= max_gap;
      end else begin
        frame_gap <= frame_diff[NS_W-1:0];
      end
    end
    if (cmd.sum) begin
      sum <= {1'b0, bank} + {1'b0, elapsed};
    end
    if (cmd.commit) begin
      render_q <= poll_live && reach;
      status_q <= ((op_q == OP_POLL) && !started) ? STATUS_NOT_INIT : STATUS_OK;
      quo      <= sum;
      rem      <= '0;
    end
    if (cmd.mod_step) begin
      quo <= {quo[SUM_W-2:0], 1'b0};
      rem <= rem_next;
    end
    if (cmd.out_load) begin
      out_item.render         <= render_q;
      out_item.frame_delta_ns <= delta_held;
      out_item.status         <= status_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_period <= RESET_PERIOD_NS;
      max_gap      <= RESET_MAX_GAP_NS;
      last_poll    <= '0;
      last_frame   <= '0;
      bank         <= '0;
      delta_held   <= RESET_PERIOD_NS;
      started      <= 1'b0;
    end else begin
      if (cmd.commit) begin
        if (op_q == OP_INIT) begin
          last_poll  <= now_q;
          last_frame <= now_q;
          delta_held <= RESET_PERIOD_NS;
          bank       <= '0;
          started    <= 1'b1;
        end else if (started) begin
          last_poll <= now_q;
          if (reach) begin
            delta_held <= frame_gap;
            last_frame <= now_q;
          end else begin
            bank <= sum[NS_W-1:0];
          end
        end
      end
      // The bank only settles on the last step; nothing reads it meanwhile.
      if (cmd.mod_step) begin
        bank <= rem_next;
      end
      if (cfg_we) begin
        if (cfg_index == REG_FRAME_PERIOD) begin
          frame_period <= cfg_data;
          bank         <= '0;
        end else begin
          max_gap <= cfg_data;
        end
      end
    end
  end

endmodule : fpa_datapath
`default_nettype wire

[rtl/frame_pacing_accumulator_core.sv]
`default_nettype none
// A result beat comes later when the poll triggers a render, as the 31-step restoring
//   remainder loop in the datapath must then work out the remainder first.
// Items are taken one at a time: the next input beat is accepted only once the
//   previous result has been loaded into the output register.
// Reset (rst, synchronous, active high) restores the register defaults and
//   clears the pacing state, leaving the block uninitialised and idle.
// ----------------------------------------------------------------------------
// frame_pacing_accumulator_core: fixed-timestep frame pacing
// Accumulates clamped poll gaps in integer nanoseconds and signals a render
// whenever a whole frame period has built up.
// ----------------------------------------------------------------------------
module frame_pacing_accumulator_core (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire fpa_pkg::in_item_t        in_item,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output fpa_pkg::out_item_t            out_item,
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_index,
  input  wire logic [fpa_pkg::NS_W-1:0] cfg_data
);
  import fpa_pkg::*;

  // The controller and the datapath talk only through these two groups.
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // The controller takes one beat at a time in its idle state. An item moves
  // through difference, clamp, sum and commit steps; a poll that reaches the
  // frame period then runs the remainder loop, reducing the accumulator modulo the
  // period. The result waits in the output register, and the controller is
  // free to take the next input beat while that result is still unclaimed.
  fpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds both configuration registers. A write to the frame
  // period also clears the accumulator. A zero period behaves as one
  // nanosecond, and a zero maximum gap clamps every gap to nothing.
  fpa_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_item),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule : frame_pacing_accumulator_core
`default_nettype wire

[rtl/fpa_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_checker: port-level checks for the frame pacing accumulator
// Watches the top-level ports only and is bound to the top level below.
// ----------------------------------------------------------------------------
module fpa_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire fpa_pkg::in_item_t  in_item,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire fpa_pkg::out_item_t out_item,
  input wire logic               cfg_we,
  input wire logic               cfg_index,
  input wire logic [fpa_pkg::NS_W-1:0] cfg_data
);
  import fpa_pkg::*;

  logic unused_ok;
  assign unused_ok = ^{in_item, cfg_we, cfg_index, cfg_data};

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn while stalled");

  // A render is only ever signalled on a successful poll.
  a_render_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.render |-> out_item.status == STATUS_OK)
    else $error("render reported together with an error status");

  // One item is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is still in progress");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat offered straight after reset");

endmodule : fpa_checker

bind frame_pacing_accumulator_core fpa_checker u_fpa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);
`default_nettype wire
